>>> src/dmxpfa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// DMX pixel frame assembler package
// Register indexes, request codes and slot decoding shared by the block.
// ---------------------------------------------------------------------------
package dmxpfa_pkg;

  localparam logic [2:0] RegBaseUniverse   = 3'd0;
  localparam logic [2:0] RegWideChannels   = 3'd1;
  localparam logic [2:0] RegAlphaPresent   = 3'd2;
  localparam logic [2:0] RegClearOnSilence = 3'd3;
  localparam logic [2:0] RegSilenceMs      = 3'd4;
  localparam logic [2:0] RegSettleUs       = 3'd5;
  localparam logic [2:0] RegMaxHoldUs      = 3'd6;
  localparam logic [2:0] RegPixelCount     = 3'd7;

  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqGroup = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;
  localparam logic [1:0] ReqNone  = 2'd3;

  localparam logic [15:0] AlphaNarrow = 16'd255;
  localparam logic [15:0] AlphaWide   = 16'd16383;

  // pixel word {red, green, blue, alpha}
  function automatic logic [63:0] decode_slot(input logic [63:0] b, input logic wide,
                                              input logic alpha);
    logic [15:0] r, g, bl, a;
    if (wide) begin
      r  = b[63:48];
      g  = b[47:32];
      bl = b[31:16];
      a  = alpha ? b[15:0] : AlphaWide;
    end else begin
      r  = {8'd0, b[63:56]};
      g  = {8'd0, b[55:48]};
      bl = {8'd0, b[47:40]};
      a  = alpha ? {8'd0, b[39:32]} : AlphaNarrow;
    end
    return {r, g, bl, a};
  endfunction

endpackage
`default_nettype wire

>>> src/dmxpfa_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Generic single port RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module dmxpfa_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> src/dmx_pixel_frame_assembler.sv
`default_nettype none
// ---------------------------------------------------------------------------
// DMX pixel frame assembler
// Maps DMX slot groups onto a pending pixel store and commits it on ticks.
// ---------------------------------------------------------------------------
// Each item passes Calc and Done; between them a read visits RdWait and RdOut,
// a group Check and, when placed, Write, a tick Check. A frame open or commit adds
// CopyRd, CopyWr per used pixel; a silence clear adds Clear per used pixel.
// One item in flight, busy high meanwhile; the next item can go in the strobe cycle.
// After reset both stores are swept to zero while busy is high.
// Results strobe on done_o for one cycle; the receiver cannot stall.
module dmx_pixel_frame_assembler #(
  parameter int MAX_PIXELS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] now_us_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [15:0] packet_universe_i,
  input  wire logic [9:0]  packet_start_channel_i,
  input  wire logic [9:0]  packet_length_i,
  input  wire logic [7:0]  group_index_i,
  input  wire logic [63:0] group_bytes_i,
  input  wire logic [9:0]  read_index_i,
  output logic             done_o,
  output logic [15:0]      red_o,
  output logic [15:0]      green_o,
  output logic [15:0]      blue_o,
  output logic [15:0]      alpha_o,
  output logic             frame_pending_o,
  output logic             stores_cleared_o
);
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = AW + 1;

  localparam logic [3:0] StInit   = 4'd0;
  localparam logic [3:0] StIdle   = 4'd1;
  localparam logic [3:0] StCalc   = 4'd2;
  localparam logic [3:0] StCheck  = 4'd3;
  localparam logic [3:0] StCopyRd = 4'd4;
  localparam logic [3:0] StCopyWr = 4'd5;
  localparam logic [3:0] StWrite  = 4'd6;
  localparam logic [3:0] StRdWait = 4'd7;
  localparam logic [3:0] StRdOut  = 4'd8;
  localparam logic [3:0] StClear  = 4'd9;
  localparam logic [3:0] StDone   = 4'd10;

  // configuration
  logic [15:0] base_q;
  logic        wide_q, alpha_q, clr_en_q;
  logic [31:0] sil_q, settle_q, hold_q;
  logic [10:0] pcount_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      wide_q   <= 1'b0;
      alpha_q  <= 1'b0;
      clr_en_q <= 1'b0;
      sil_q    <= 32'd5000;
      settle_q <= 32'd2000;
      hold_q   <= 32'd20000;
      pcount_q <= 11'd1024;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dmxpfa_pkg::RegBaseUniverse:   base_q   <= cfg_data_i[15:0];
        dmxpfa_pkg::RegWideChannels:   wide_q   <= cfg_data_i[0];
        dmxpfa_pkg::RegAlphaPresent:   alpha_q  <= cfg_data_i[0];
        dmxpfa_pkg::RegClearOnSilence: clr_en_q <= cfg_data_i[0];
        dmxpfa_pkg::RegSilenceMs:      sil_q    <= cfg_data_i;
        dmxpfa_pkg::RegSettleUs:       settle_q <= cfg_data_i;
        dmxpfa_pkg::RegMaxHoldUs:      hold_q   <= cfg_data_i;
        dmxpfa_pkg::RegPixelCount:     pcount_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] used;
  assign used = ({21'd0, pcount_q} > 32'(MAX_PIXELS)) ? CW'(MAX_PIXELS)
                                                      : CW'(pcount_q);

  // state
  logic [3:0]  st_q;
  logic        pend_q, clrd_q;
  logic [31:0] lpk_q, fst_q, lrx_q;
  logic [1:0]  req_q;
  logic [31:0] us_q, ms_q;
  logic [9:0]  ridx_q;
  logic [7:0]  gi_q;
  logic [63:0] bytes_q;
  logic [7:0]  per_q;
  logic [8:0]  chan_q, groups_q;
  logic signed [16:0] rel_q;
  logic signed [31:0] pix_q;
  logic [CW-1:0] cnt_q;
  logic [63:0] out_q;
  logic        done_q, commit_q;

  // per slot size constants from a small table
  logic [3:0] slot;
  assign slot = (alpha_q ? 4'd4 : 4'd3) << wide_q;
  logic [7:0] per_uni;
  always_comb begin
    case (slot)
      4'd3:    per_uni = 8'd170;
      4'd4:    per_uni = 8'd128;
      4'd6:    per_uni = 8'd85;
      default: per_uni = 8'd64;
    endcase
  end

  // divide a 10 bit value by the slot size (3, 4, 6, 8)
  function automatic logic [8:0] div_slot(input logic [9:0] v, input logic [3:0] s);
    logic [20:0] m;
    logic [8:0]  res;
    case (s)
      4'd3: begin
        m   = 21'(v) * 21'd683;
        res = m[19:11];
      end
      4'd6: begin
        m   = 21'(v) * 21'd683;
        res = m[20:12];
      end
      4'd4: begin
        m   = '0;
        res = {1'b0, v[9:2]};
      end
      default: begin
        m   = '0;
        res = {2'b0, v[9:3]};
      end
    endcase
    return res;
  endfunction

  // memories
  logic          c_we, p_we;
  logic [AW-1:0] c_addr, p_addr;
  logic [63:0]   c_wd, p_wd, c_rd, p_rd;

  dmxpfa_ram #(.Width(64), .Depth(MAX_PIXELS)) u_committed (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wd), .rdata_o(c_rd)
  );
  dmxpfa_ram #(.Width(64), .Depth(MAX_PIXELS)) u_pending (
    .clk_i, .we_i(p_we), .addr_i(p_addr), .wdata_i(p_wd), .rdata_o(p_rd)
  );

  logic take;
  assign busy = (st_q != StIdle);
  assign take = start && !busy;

  logic do_commit, do_clear;
  assign do_commit = pend_q && (((us_q - lpk_q) >= settle_q) || ((us_q - fst_q) >= hold_q));
  assign do_clear  = clr_en_q && !clrd_q && ((ms_q - lrx_q) > sil_q);

  logic last;
  assign last = (cnt_q + CW'(1)) >= used;

  logic [AW-1:0] cidx, pidx;
  assign cidx = cnt_q[AW-1:0];
  assign pidx = pix_q[AW-1:0];

  logic        grp_ok;
  assign grp_ok = ({1'b0, gi_q} < groups_q) && (pix_q >= 0) &&
                  (pix_q < 32'($unsigned(used)));

  always_comb begin
    c_we   = 1'b0;
    p_we   = 1'b0;
    c_addr = cidx;
    p_addr = cidx;
    c_wd   = '0;
    p_wd   = '0;
    case (st_q)
      StInit: begin
        c_we = 1'b1;
        p_we = 1'b1;
      end
      StCopyRd: begin
        // copy direction: commit moves pending to committed, else the reverse
        c_addr = cidx;
        p_addr = cidx;
      end
      StCopyWr: begin
        c_we = commit_q;
        p_we = !commit_q;
        c_wd = p_rd;
        p_wd = c_rd;
      end
      StWrite: begin
        p_we   = 1'b1;
        p_addr = pidx;
        p_wd   = dmxpfa_pkg::decode_slot(bytes_q, wide_q, alpha_q);
      end
      StRdWait: begin
        c_addr = ridx_q[AW-1:0];
      end
      StClear: begin
        c_we = (used != '0);
        p_we = (used != '0);
      end
      default: ;
    endcase
  end

  logic [31:0] rel_prod;
  assign rel_prod = 32'(rel_q * $signed({1'b0, per_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StInit;
      pend_q   <= 1'b0;
      clrd_q   <= 1'b0;
      lpk_q    <= '0;
      fst_q    <= '0;
      lrx_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      commit_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        StInit: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(MAX_PIXELS - 1)) begin
            st_q <= StIdle;
          end
        end
        StIdle: begin
          if (take) begin
            st_q <= StCalc;
          end
        end
        StCalc: begin
          cnt_q <= '0;
          out_q <= '0;
          case (req_q)
            dmxpfa_pkg::ReqTick: begin
              if (do_commit) begin
                commit_q <= 1'b1;
                pend_q   <= 1'b0;
                st_q     <= (used != '0) ? StCopyRd : StCheck;
              end else begin
                st_q <= StCheck;
              end
            end
            dmxpfa_pkg::ReqGroup: begin
              pix_q <= rel_prod + 32'(chan_q) + 32'(gi_q);
              st_q  <= StCheck;
            end
            dmxpfa_pkg::ReqRead: begin
              st_q <= (ridx_q < 10'(MAX_PIXELS > 1023 ? 1023 : MAX_PIXELS)) ||
                      (MAX_PIXELS > 1023) ? StRdWait : StDone;
            end
            default: st_q <= StDone;
          endcase
        end
        StCheck: begin
          if (req_q == dmxpfa_pkg::ReqTick) begin
            if (do_clear) begin
              pend_q <= 1'b0;
              clrd_q <= 1'b1;
              cnt_q  <= '0;
              st_q   <= (used != '0) ? StClear : StDone;
            end else begin
              st_q <= StDone;
            end
          end else if (grp_ok) begin
            lpk_q  <= us_q;
            lrx_q  <= ms_q;
            clrd_q <= 1'b0;
            if (!pend_q) begin
              pend_q   <= 1'b1;
              fst_q    <= us_q;
              commit_q <= 1'b0;
              cnt_q    <= '0;
              st_q     <= StCopyRd;
            end else begin
              st_q <= StWrite;
            end
          end else begin
            st_q <= StDone;
          end
        end
        StCopyRd: st_q <= StCopyWr;
        StCopyWr: begin
          cnt_q <= cnt_q + CW'(1);
          if (last) begin
            st_q <= commit_q ? StCheck : StWrite;
          end else begin
            st_q <= StCopyRd;
          end
        end
        StWrite: st_q <= StDone;
        StRdWait: st_q <= StRdOut;
        StRdOut: begin
          out_q <= c_rd;
          st_q  <= StDone;
        end
        StClear: begin
          cnt_q <= cnt_q + CW'(1);
          if (last) begin
            st_q <= StDone;
          end
        end
        StDone: begin
          done_q <= 1'b1;
          st_q   <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // item capture and derived address terms (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q    <= req_type_i;
      us_q     <= now_us_i;
      ms_q     <= now_ms_i;
      gi_q     <= group_index_i;
      bytes_q  <= group_bytes_i;
      ridx_q   <= read_index_i;
      per_q    <= per_uni;
      rel_q    <= $signed({1'b0, packet_universe_i}) - $signed({1'b0, base_q});
      chan_q   <= div_slot((packet_start_channel_i == 10'd0) ? 10'd0
                           : packet_start_channel_i - 10'd1, slot);
      groups_q <= div_slot(packet_length_i, slot);
    end
  end

  assign done_o           = done_q;
  assign red_o            = out_q[63:48];
  assign green_o          = out_q[47:32];
  assign blue_o           = out_q[31:16];
  assign alpha_o          = out_q[15:0];
  assign frame_pending_o  = pend_q;
  assign stores_cleared_o = clrd_q;
endmodule
`default_nettype wire

>>> src/dmxpfa_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// DMX pixel frame assembler checker
// Port level properties of the command handshake and result flags.
// ---------------------------------------------------------------------------
module dmxpfa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic        frame_pending_o,
  input wire logic        stores_cleared_o
);
  // a transfer always makes the block busy next cycle
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  // result strobe ends the work of the item
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy during result");

  // strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  // flags only move while an item is at work
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !$past(busy)) |-> ($stable(frame_pending_o) && $stable(stores_cleared_o)))
    else $error("flags changed while idle");
endmodule

bind dmx_pixel_frame_assembler dmxpfa_checker u_dmxpfa_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o,
  .frame_pending_o, .stores_cleared_o
);
`default_nettype wire
